/* design/cwd_pkg.sv */
`timescale 1ns / 1ps
// Package for the codeword window detector: widths, reset values and
// the request type between the top level and the codebook map.
// No dependencies.
package cwd_pkg;

  // Default number of slice offsets searched for a codeword.
  localparam int SEARCH_OFFSETS_DEF = 8;

  // Field widths.
  localparam int WINDOW_W  = 32;
  localparam int WORD_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int PREFIX_W  = 4;
  localparam int INDEX_W   = 12;
  localparam int HISTORY_W = 32;

  // Target search covers the slices at bit offsets 16 down to 0.
  localparam int TARGET_OFFSETS = WINDOW_W - WORD_W + 1;

  // Reset value of the prefix register.
  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 4'b1110;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  // Codebook map layout: 4096 bits stored as 512 rows of 8 bits.
  localparam int ROW_W     = 8;
  localparam int BIT_AW    = $clog2(ROW_W);
  localparam int MAP_ROWS  = (1 << INDEX_W) / ROW_W;
  localparam int ROW_AW    = $clog2(MAP_ROWS);

  // Access request from the control logic to the codebook map.
  typedef struct packed {
    logic               rd_en;
    logic [INDEX_W-1:0] rd_index;
    logic               set_en;
    logic [INDEX_W-1:0] set_index;
  } map_req_t;

endpackage

/* design/codeword_window_detector_top.sv */
`timescale 1ns / 1ps
// Top level of the codeword window detector: control, window, history and
// output register. Depends on cwd_pkg and cwd_codebook.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------
//  in      | in_valid / in_stall       | command, data_byte, entry_word,
//          |                           | target_word, pin_level
//  out     | out_valid / out_stall     | found_valid, found_word, event_seen,
//          |                           | newest_word, older_word, target_hit,
//          |                           | flag_level
//  cfg     | cfg_we                    | cfg_wdata (prefix_value)
//
// A data word passes through the accept cycle, a map read on the single read port of
// the codebook memory at each offset whose slice has the prefix, a drain state for the
// last read data and a finish state that forms the result; a hit ends the search early.
// A load word whose prefix matches passes through accept, read, write back and result;
// any other load word through accept and result. After reset the codebook memory is
// cleared, during which in_stall is high. The output register holds a finished word
// under out_stall while the next input word is accepted and worked on.
module codeword_window_detector_top #(
  parameter int SEARCH_OFFSETS = cwd_pkg::SEARCH_OFFSETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cwd_pkg::PREFIX_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [cwd_pkg::BYTE_W-1:0]    data_byte,
  input  logic [cwd_pkg::WORD_W-1:0]    entry_word,
  input  logic [cwd_pkg::WORD_W-1:0]    target_word,
  input  logic                          pin_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found_valid,
  output logic [cwd_pkg::WORD_W-1:0]    found_word,
  output logic                          event_seen,
  output logic [cwd_pkg::WORD_W-1:0]    newest_word,
  output logic [cwd_pkg::WORD_W-1:0]    older_word,
  output logic                          target_hit,
  output logic                          flag_level
);

  localparam int OFF_W = (SEARCH_OFFSETS > 1) ? $clog2(SEARCH_OFFSETS) : 1;
  localparam int WORD_W = cwd_pkg::WORD_W;
  localparam int IDX_W  = cwd_pkg::INDEX_W;
  localparam int PRE_W  = cwd_pkg::PREFIX_W;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_LOOKUP  = 6'b000010,
    S_DRAIN   = 6'b000100,
    S_LOAD_RD = 6'b001000,
    S_LOAD_WR = 6'b010000,
    S_FINISH  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [PRE_W-1:0]            prefix_value;
  logic [cwd_pkg::WINDOW_W-1:0] bit_window;
  logic [cwd_pkg::HISTORY_W-1:0] found_history;
  logic                        expect_low;
  logic                        out_level;

  logic                        is_load;
  logic [WORD_W-1:0]           entry_q;
  logic [WORD_W-1:0]           target_q;
  logic                        pin_q;
  logic [OFF_W-1:0]            off_idx;
  logic                        pend;
  logic [WORD_W-1:0]           pend_slice;
  logic                        hit_found;
  logic [WORD_W-1:0]           hit_word;

  logic                        accept;
  logic                        out_free;
  logic [cwd_pkg::WINDOW_W-1:0] win_shift;
  logic [WORD_W-1:0]           slice;
  logic                        slice_pre_ok;
  logic                        pend_hit;
  logic                        map_busy;
  logic                        map_bit;
  cwd_pkg::map_req_t           map_req;

  logic [cwd_pkg::HISTORY_W-1:0] history_next;
  logic                        event_now;
  logic                        target_any;

  // Codebook map memory.
  cwd_codebook u_codebook (
    .clk    (clk),
    .rst    (rst),
    .req    (map_req),
    .busy   (map_busy),
    .rd_bit (map_bit)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || map_busy;
  assign out_free = !out_valid || !out_stall;

  // Slice at the current search offset.
  assign win_shift    = bit_window >> off_idx;
  assign slice        = win_shift[WORD_W-1:0];
  assign slice_pre_ok = (slice[WORD_W-1:IDX_W] == prefix_value);
  assign pend_hit     = pend && map_bit;

  // Map requests: lookups during the search, read then set for a load.
  always_comb begin
    map_req.rd_en     = ((state == S_LOOKUP) && slice_pre_ok) || (state == S_LOAD_RD);
    map_req.rd_index  = (state == S_LOAD_RD) ? entry_q[IDX_W-1:0] : slice[IDX_W-1:0];
    map_req.set_en    = (state == S_LOAD_WR);
    map_req.set_index = entry_q[IDX_W-1:0];
  end

  // Result of a data word: history, event and target search.
  always_comb begin
    history_next = hit_found ? {found_history[WORD_W-1:0], hit_word} : found_history;
    event_now    = expect_low ? !pin_q : pin_q;
    target_any   = 1'b0;
    for (int i = 0; i < cwd_pkg::TARGET_OFFSETS; i++) begin
      if (bit_window[i +: WORD_W] == target_q) begin
        target_any = 1'b1;
      end
    end
  end

  // Control sequence.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == cwd_pkg::CMD_DATA) begin
            state_next = S_LOOKUP;
          end else if (entry_word[WORD_W-1:IDX_W] == prefix_value) begin
            state_next = S_LOAD_RD;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_LOOKUP: begin
        if (pend_hit) begin
          state_next = S_FINISH;
        end else if (off_idx == '0) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:   state_next = S_FINISH;
      S_LOAD_RD: state_next = S_LOAD_WR;
      S_LOAD_WR: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Control registers and block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prefix_value  <= cwd_pkg::PREFIX_RESET;
      bit_window    <= '0;
      found_history <= '0;
      expect_low    <= 1'b0;
      out_level     <= 1'b0;
      out_valid     <= 1'b0;
      pend          <= 1'b0;
      hit_found     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        prefix_value <= cfg_wdata;
      end
      // The output word is loaded at the end of an item and dropped once taken.
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          pend      <= 1'b0;
          hit_found <= 1'b0;
          if (accept && (command == cwd_pkg::CMD_DATA)) begin
            bit_window <= {bit_window[cwd_pkg::WINDOW_W-cwd_pkg::BYTE_W-1:0], data_byte};
          end
        end
        S_LOOKUP: begin
          pend <= slice_pre_ok;
          if (pend_hit) begin
            hit_found <= 1'b1;
          end
        end
        S_DRAIN: begin
          pend <= 1'b0;
          if (pend_hit) begin
            hit_found <= 1'b1;
          end
        end
        S_FINISH: begin
          if (out_free && !is_load) begin
            found_history <= history_next;
            if (event_now) begin
              expect_low <= !expect_low;
            end else if (target_any) begin
              out_level <= !out_level;
            end
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

  // Item payload and search bookkeeping.
  always_ff @(posedge clk) begin
    if (accept) begin
      is_load  <= (command == cwd_pkg::CMD_LOAD);
      entry_q  <= entry_word;
      target_q <= target_word;
      pin_q    <= pin_level;
      off_idx  <= OFF_W'(SEARCH_OFFSETS - 1);
    end else if (state == S_LOOKUP) begin
      off_idx <= off_idx - 1'b1;
    end
    if (state == S_LOOKUP) begin
      pend_slice <= slice;
    end
    if (((state == S_LOOKUP) || (state == S_DRAIN)) && pend_hit) begin
      hit_word <= pend_slice;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      if (is_load) begin
        found_valid <= 1'b0;
        found_word  <= '0;
        event_seen  <= 1'b0;
        newest_word <= '0;
        older_word  <= '0;
        target_hit  <= 1'b0;
        flag_level  <= out_level;
      end else begin
        found_valid <= hit_found;
        found_word  <= hit_found ? hit_word : '0;
        event_seen  <= event_now;
        newest_word <= event_now ? history_next[WORD_W-1:0] : '0;
        older_word  <= event_now ? history_next[cwd_pkg::HISTORY_W-1:WORD_W] : '0;
        target_hit  <= !event_now && target_any;
        flag_level  <= out_level ^ (!event_now && target_any);
      end
    end
  end

endmodule

/* design/cwd_codebook.sv */
`timescale 1ns / 1ps
// Codebook map: 4096 one-bit entries in a synchronous 512 x 8 memory,
// with a clearing pass after reset and read-modify-write for setting bits.
// Depends on cwd_pkg.
module cwd_codebook (
  input  logic              clk,
  input  logic              rst,
  input  cwd_pkg::map_req_t req,
  output logic              busy,
  output logic              rd_bit
);

  logic [cwd_pkg::ROW_W-1:0]  mem [cwd_pkg::MAP_ROWS];
  logic [cwd_pkg::ROW_W-1:0]  rd_row;
  logic [cwd_pkg::BIT_AW-1:0] rd_sel;
  logic [cwd_pkg::ROW_AW-1:0] clr_row;

  logic                       wr_en;
  logic [cwd_pkg::ROW_AW-1:0] wr_row;
  logic [cwd_pkg::ROW_W-1:0]  wr_data;
  logic [cwd_pkg::ROW_W-1:0]  set_mask;

  // Clearing pass: one row per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == cwd_pkg::ROW_AW'(cwd_pkg::MAP_ROWS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // The set request comes the cycle after the read of the same row, so the
  // registered row is the current content and is written back with one bit set.
  always_comb begin
    set_mask = '0;
    set_mask[req.set_index[cwd_pkg::BIT_AW-1:0]] = 1'b1;
    if (busy) begin
      wr_en   = 1'b1;
      wr_row  = clr_row;
      wr_data = '0;
    end else begin
      wr_en   = req.set_en;
      wr_row  = req.set_index[cwd_pkg::INDEX_W-1:cwd_pkg::BIT_AW];
      wr_data = rd_row | set_mask;
    end
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  // Memory read port with registered data.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_row <= mem[req.rd_index[cwd_pkg::INDEX_W-1:cwd_pkg::BIT_AW]];
      rd_sel <= req.rd_index[cwd_pkg::BIT_AW-1:0];
    end
  end

  assign rd_bit = rd_row[rd_sel];

endmodule

/* design/cwd_checker.sv */
`timescale 1ns / 1ps
// Port checker for the codeword window detector, bound to the top level.
// Depends on cwd_pkg for widths.
module cwd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         found_valid,
  input logic [cwd_pkg::WORD_W-1:0]   found_word,
  input logic                         event_seen,
  input logic [cwd_pkg::WORD_W-1:0]   newest_word,
  input logic [cwd_pkg::WORD_W-1:0]   older_word,
  input logic                         target_hit
);

  // A stalled output word stays valid, with found_word and newest_word unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found_word) && $stable(newest_word))
    else $error("stalled output word changed");

  // With no codeword found the word field is zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !found_valid |-> found_word == '0)
    else $error("found_word nonzero without a codeword");

  // A target hit is only reported on a word without an event, and the
  // history halves are only reported on an event.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && target_hit |-> !event_seen)
    else $error("target hit reported together with an event");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_seen |-> newest_word == '0 && older_word == '0)
    else $error("history reported without an event");

  // After reset the map is being cleared, so input is held off.
  assert property (@(posedge clk) rst |=> in_stall && !out_valid)
    else $error("input accepted right after reset");

endmodule

bind codeword_window_detector_top cwd_checker u_cwd_checker (.*);
